// ===== hdl/hcs_pkg.sv =====
// shared types, constants and mod-26 helpers for the hill cipher stream
`default_nettype none

package hcs_pkg;

    localparam int MAX_ORDER = 3;
    localparam int KEY_W = 45;
    localparam int CFG_IDX_W = 2;
    localparam int JOB_DEPTH = 2;
    localparam int LETTERS = 26;

    localparam logic [1:0] RESET_BLOCK_SIZE = 2'd2;
    localparam logic [KEY_W-1:0] RESET_KEY = 45'd1099512676353;
    localparam logic [4:0] PAD_LETTER = 5'd23;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE   = 2'd0,
        CFG_KEY_MATRIX   = 2'd1,
        CFG_DECRYPT_MODE = 2'd2
    } t_cfg_idx;

    // nine 5-bit entries, row r column c at index 3r+c
    typedef logic [8:0][4:0] t_mat;

    typedef struct packed {
        logic busy;
        logic order3;
        logic key_ok;
        logic clr_held;
    } t_key_ctl;

    typedef struct packed {
        logic [2:0][4:0] vec;
        logic            order3;
        logic            last;
        logic            err;
    } t_job;

    function automatic logic [4:0] red26(input logic [4:0] e);
        return (e >= 5'(LETTERS)) ? e - 5'(LETTERS) : e;
    endfunction

    // reduces any value below 3328 by binary steps of 26 * 2^k
    function automatic logic [4:0] mod26(input logic [11:0] v);
        logic [11:0] r;
        r = v;
        if (r >= 12'd1664) r = r - 12'd1664;
        if (r >= 12'd832)  r = r - 12'd832;
        if (r >= 12'd416)  r = r - 12'd416;
        if (r >= 12'd208)  r = r - 12'd208;
        if (r >= 12'd104)  r = r - 12'd104;
        if (r >= 12'd52)   r = r - 12'd52;
        if (r >= 12'd26)   r = r - 12'd26;
        return r[4:0];
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic logic [4:0] inv26(input logic [4:0] d);
        logic [4:0] r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        return ({2'b00, row} << 1) + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hcs_keygen.sv =====
// configuration registers and the sequencer that builds the working matrix
`default_nettype none

module hcs_keygen import hcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [KEY_W-1:0]     i_cfg_data,
    output t_key_ctl                  o_ctl,
    output t_mat                      o_eff
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COF,
        S_DET,
        S_INV,
        S_ADJ
    } t_state;

    t_state           r_state;
    logic [1:0]       r_block_size;
    logic [KEY_W-1:0] r_key;
    logic             r_decrypt;
    logic [1:0]       r_i;
    logic [1:0]       r_j;
    t_mat             r_cof;
    logic [4:0]       r_det;
    logic [4:0]       r_invdet;
    t_mat             r_eff;
    logic             r_key_ok;

    logic             order3;
    t_mat             m;
    logic [4:0]       op_a, op_b, op_c, op_d;
    logic [9:0]       prod_ab, prod_cd;
    logic [4:0]       cof_val;
    logic [11:0]      det_sum;
    logic [4:0]       det_val;
    logic [9:0]       adj_prod;
    logic [4:0]       adj_val;
    logic             last_pos;

    assign order3 = (r_block_size == 2'd3) && (MAX_ORDER >= 3);

    // order two is embedded as a block diagonal with a one in the corner
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = red26(r_key[5*k +: 5]);
        end
        if (!order3) begin
            m[2] = 5'd0;
            m[5] = 5'd0;
            m[6] = 5'd0;
            m[7] = 5'd0;
            m[8] = 5'd1;
        end
    end

    // signed cofactor of (i,j) from the cyclic minor
    always_comb begin
        case ({r_i, r_j})
            4'b0000: begin op_a = m[4]; op_b = m[8]; op_c = m[5]; op_d = m[7]; end
            4'b0001: begin op_a = m[5]; op_b = m[6]; op_c = m[3]; op_d = m[8]; end
            4'b0010: begin op_a = m[3]; op_b = m[7]; op_c = m[4]; op_d = m[6]; end
            4'b0100: begin op_a = m[7]; op_b = m[2]; op_c = m[8]; op_d = m[1]; end
            4'b0101: begin op_a = m[8]; op_b = m[0]; op_c = m[6]; op_d = m[2]; end
            4'b0110: begin op_a = m[6]; op_b = m[1]; op_c = m[7]; op_d = m[0]; end
            4'b1000: begin op_a = m[1]; op_b = m[5]; op_c = m[2]; op_d = m[4]; end
            4'b1001: begin op_a = m[2]; op_b = m[3]; op_c = m[0]; op_d = m[5]; end
            4'b1010: begin op_a = m[0]; op_b = m[4]; op_c = m[1]; op_d = m[3]; end
            default: begin op_a = 5'd0; op_b = 5'd0; op_c = 5'd0; op_d = 5'd0; end
        endcase
    end

    assign prod_ab = {5'b0, op_a} * {5'b0, op_b};
    assign prod_cd = {5'b0, op_c} * {5'b0, op_d};
    // bias by 26*26 keeps the difference non-negative
    assign cof_val = mod26({2'b00, prod_ab} + 12'd676 - {2'b00, prod_cd});

    assign det_sum = {2'b00, {5'b0, m[0]} * {5'b0, r_cof[0]}}
                   + {2'b00, {5'b0, m[1]} * {5'b0, r_cof[1]}}
                   + {2'b00, {5'b0, m[2]} * {5'b0, r_cof[2]}};
    assign det_val = mod26(det_sum);

    assign adj_prod = {5'b0, r_cof[idx3(r_i, r_j)]} * {5'b0, r_invdet};
    assign adj_val  = mod26({2'b00, adj_prod});

    assign last_pos = (r_i == 2'd2) && (r_j == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_COF;
            r_block_size <= RESET_BLOCK_SIZE;
            r_key        <= RESET_KEY;
            r_decrypt    <= 1'b0;
            r_i          <= 2'd0;
            r_j          <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCK_SIZE:   r_block_size <= i_cfg_data[1:0];
                CFG_KEY_MATRIX:   r_key        <= i_cfg_data;
                CFG_DECRYPT_MODE: r_decrypt    <= i_cfg_data[0];
                default: ;
            endcase
            r_state <= S_COF;
            r_i     <= 2'd0;
            r_j     <= 2'd0;
        end else begin
            case (r_state)
                S_COF: begin
                    r_cof[idx3(r_i, r_j)] <= cof_val;
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                    if (last_pos) begin
                        r_state <= S_DET;
                    end
                end
                S_DET: begin
                    if (r_decrypt) begin
                        r_det   <= det_val;
                        r_state <= S_INV;
                    end else begin
                        r_eff    <= m;
                        r_key_ok <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_INV: begin
                    r_invdet <= inv26(r_det);
                    r_key_ok <= (inv26(r_det) != 5'd0);
                    r_i      <= 2'd0;
                    r_j      <= 2'd0;
                    r_state  <= S_ADJ;
                end
                S_ADJ: begin
                    // adjugate is the transpose of the cofactor matrix
                    r_eff[idx3(r_j, r_i)] <= adj_val;
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                    if (last_pos) begin
                        r_state <= S_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ctl.busy     = (r_state != S_IDLE);
    assign o_ctl.order3   = order3;
    assign o_ctl.key_ok   = r_key_ok;
    assign o_ctl.clr_held = i_cfg_we && (i_cfg_idx == CFG_BLOCK_SIZE);
    assign o_eff          = r_eff;

endmodule

`default_nettype wire

// ===== hdl/hcs_front.sv =====
// input side: letter filter, block gathering, padding and job issue
`default_nettype none

module hcs_front import hcs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_end_of_text,
    input  wire t_key_ctl   i_ctl,
    input  wire logic       i_job_full,
    output logic            o_job_push,
    output t_job            o_job
);

    logic [1:0]      r_held;
    logic [2:0][4:0] r_letters;

    logic            accept;
    logic            is_letter;
    logic [7:0]      offset;
    logic [4:0]      letter;
    logic            take;
    logic [1:0]      last_slot;
    logic            complete;
    logic [2:0][4:0] vec;

    assign o_full = i_ctl.busy || i_job_full;
    assign accept = i_push && !o_full;

    always_comb begin
        is_letter = 1'b0;
        offset    = 8'd0;
        if (i_char_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            is_letter = 1'b1;
            offset    = i_char_byte - CHAR_UPPER_A;
        end else if (i_char_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            is_letter = 1'b1;
            offset    = i_char_byte - CHAR_LOWER_A;
        end
    end

    assign letter    = offset[4:0];
    // with a singular key in decrypt mode letters are dropped
    assign take      = is_letter && i_ctl.key_ok;
    assign last_slot = i_ctl.order3 ? 2'd2 : 2'd1;
    assign complete  = take && (r_held == last_slot);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < r_held) begin
                vec[k] = r_letters[k];
            end else if ((2'(k) == r_held) && take) begin
                vec[k] = letter;
            end else begin
                vec[k] = PAD_LETTER;
            end
        end
        if (!i_ctl.order3) begin
            vec[2] = 5'd0;
        end
    end

    always_comb begin
        if (i_end_of_text) begin
            o_job_push = accept && (!i_ctl.key_ok || take || (r_held != 2'd0));
        end else begin
            o_job_push = accept && complete;
        end
        o_job.err    = !i_ctl.key_ok;
        o_job.last   = i_end_of_text;
        o_job.order3 = i_ctl.order3;
        o_job.vec    = i_ctl.key_ok ? vec : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
        end else if (i_ctl.clr_held) begin
            r_held <= 2'd0;
        end else if (accept) begin
            if (i_end_of_text || complete) begin
                r_held <= 2'd0;
            end else if (take) begin
                r_held <= r_held + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && take && !complete && !i_end_of_text) begin
            r_letters[r_held] <= letter;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hcs_job_queue.sv =====
// short queue of block jobs between the front and back halves
`default_nettype none

module hcs_job_queue import hcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hcs_back.sv =====
// result side: one matrix row times the block vector per cycle, output register
`default_nettype none

module hcs_back import hcs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mat       i_eff,
    input  wire logic       i_job_empty,
    input  wire t_job       i_job,
    output logic            o_job_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [4:0]      o_letter_index,
    output logic            o_last,
    output logic            o_status
);

    logic       r_out_valid;
    logic [1:0] r_row;
    logic [4:0] r_letter;
    logic       r_last;
    logic       r_status;

    logic       adv;
    logic [4:0] e0, e1, e2;
    logic [11:0] dot;
    logic [4:0] row_val;
    logic [1:0] last_row;
    logic       row_end;

    // a new result moves in when the output slot is free or being taken
    assign adv = !i_job_empty && (!r_out_valid || i_pop);

    always_comb begin
        case (r_row)
            2'd0:    begin e0 = i_eff[0]; e1 = i_eff[1]; e2 = i_eff[2]; end
            2'd1:    begin e0 = i_eff[3]; e1 = i_eff[4]; e2 = i_eff[5]; end
            default: begin e0 = i_eff[6]; e1 = i_eff[7]; e2 = i_eff[8]; end
        endcase
    end

    assign dot = {2'b00, {5'b0, e0} * {5'b0, i_job.vec[0]}}
               + {2'b00, {5'b0, e1} * {5'b0, i_job.vec[1]}}
               + {2'b00, {5'b0, e2} * {5'b0, i_job.vec[2]}};
    assign row_val = mod26(dot);

    assign last_row  = i_job.order3 ? 2'd2 : 2'd1;
    assign row_end   = i_job.err || (r_row == last_row);
    assign o_job_pop = adv && row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_row       <= 2'd0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_row       <= row_end ? 2'd0 : r_row + 2'd1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_letter <= i_job.err ? 5'd0 : row_val;
            r_last   <= i_job.err || (i_job.last && row_end);
            r_status <= i_job.err;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_letter_index = r_letter;
    assign o_last         = r_last;
    assign o_status       = r_status;

endmodule

`default_nettype wire

// ===== hdl/hill_cipher_stream.sv =====
// hill cipher mod 26 over text bytes: top level
// Usage: text bytes go in through push/full, one per cycle; the byte is taken
// when push is high and full is low, with end_of_text on the final byte.
// Non-letters are dropped, lower case folds to upper, and each block of 2 or 3
// letters gives that many letter indices through empty/pop, oldest first.
// A result is on the output ports while empty is low and leaves on pop.
// The byte that completes a block becomes a queued job; its results pass
// through the output register and follow one per cycle while pop is high, so a
// stream of one byte a cycle is sustained (n results drain while the next n
// letters arrive). A partial block at end of text is padded with X; the final
// result has last set. With a singular key in decrypt mode one error result
// (status 1) ends the text. The key path is a sequencer over cofactors and
// adjugate: after reset and after every configuration write full stays high
// while the working matrix is rebuilt (S_COF, S_DET, and in decrypt mode
// S_INV and S_ADJ). If the receiver stalls, one result waits in the output
// register and up to two block jobs queue behind it, after which full rises.
// Reset is synchronous and clears the queue, the output and any partial block,
// and restores block size 2, the identity key and encrypt mode.
`default_nettype none

module hill_cipher_stream import hcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_char_byte,
    input  wire logic                 i_end_of_text,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [4:0]                o_letter_index,
    output logic                      o_last,
    output logic                      o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [KEY_W-1:0]     i_cfg_data
);

    t_key_ctl ctl;
    t_mat     eff;
    logic     job_push;
    t_job     job_in;
    logic     job_full;
    logic     job_pop;
    t_job     job_head;
    logic     job_empty;

    hcs_keygen u_keygen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (ctl),
        .o_eff      (eff)
    );

    hcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_char_byte   (i_char_byte),
        .i_end_of_text (i_end_of_text),
        .i_ctl         (ctl),
        .i_job_full    (job_full),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    hcs_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_head),
        .o_empty (job_empty)
    );

    hcs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eff          (eff),
        .i_job_empty    (job_empty),
        .i_job          (job_head),
        .o_job_pop      (job_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_letter_index (o_letter_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    // no request may enter while the working matrix is being rebuilt
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.busy |-> full)
        else $error("input open while key sequencer busy");

    a_cfg_starts_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> full)
        else $error("configuration write did not close the input");

    a_letter_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_letter_index < 5'd26))
        else $error("letter index out of range");

    a_error_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (o_last && (o_letter_index == 5'd0)))
        else $error("error result not last or not zero");

endmodule

`default_nettype wire

// ===== bench/hill_cipher_stream_tb.sv =====
// self-checking testbench for the hill cipher stream: directed texts, then random texts
`default_nettype none

module hill_cipher_stream_tb import hcs_pkg::*;;

    localparam int MODULUS = 26;
    localparam int PAD_INDEX = 23;
    localparam int RANDOM_ITEMS = 120;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // classic keys: a 2x2 and a 3x3 that are both invertible mod 26
    localparam logic [KEY_W-1:0] KEY_PAIR =
        {5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd2, 5'd0, 5'd3, 5'd3};
    localparam logic [KEY_W-1:0] KEY_TRIPLE =
        {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6};
    // identity written with entries above 25
    localparam logic [KEY_W-1:0] KEY_WRAPPED =
        {5'd27, 5'd26, 5'd26, 5'd26, 5'd27, 5'd26, 5'd26, 5'd26, 5'd27};

    typedef struct packed {
        logic [4:0] letter;
        logic       last;
        logic       status;
    } t_cipher_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           i_char_byte = 8'd0;
    logic                 i_end_of_text = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [4:0]           o_letter_index;
    logic                 o_last;
    logic                 o_status;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_BLOCK_SIZE;
    logic [KEY_W-1:0]     i_cfg_data = '0;

    hill_cipher_stream i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_byte    (i_char_byte),
        .i_end_of_text  (i_end_of_text),
        .empty          (empty),
        .pop            (pop),
        .o_letter_index (o_letter_index),
        .o_last         (o_last),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // mirror of the block's registers and letter buffer
    logic [1:0]       mirror_order = RESET_BLOCK_SIZE;
    logic [KEY_W-1:0] mirror_key = RESET_KEY;
    logic             mirror_decrypt = 1'b0;
    logic [4:0]       held_letters [3];
    int               held_count = 0;

    int          key_entry [3][3];
    int          cipher_mat [3][3];
    t_cipher_out block_out [3];

    t_cipher_out expected_out [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          pop_left = 0;
    logic        pop_level = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int wrap26(input int v);
        int r;
        r = v % MODULUS;
        return (r < 0) ? r + MODULUS : r;
    endfunction

    // fills cipher_mat with the key or its inverse; 0 when decrypt has no inverse
    function automatic bit load_cipher_matrix(input logic [KEY_W-1:0] key, input bit dec,
                                              input int n);
        int r, c, det, det_inv, ra, rb, ca, cb, minor;
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                key_entry[r][c] = int'(key[5*(3*r+c) +: 5]) % MODULUS;
        if (!dec) begin
            cipher_mat = key_entry;
            return 1'b1;
        end
        if (n == 2)
            det = key_entry[0][0] * key_entry[1][1] - key_entry[0][1] * key_entry[1][0];
        else
            det = key_entry[0][0] * (key_entry[1][1] * key_entry[2][2]
                                     - key_entry[1][2] * key_entry[2][1])
                - key_entry[0][1] * (key_entry[1][0] * key_entry[2][2]
                                     - key_entry[1][2] * key_entry[2][0])
                + key_entry[0][2] * (key_entry[1][0] * key_entry[2][1]
                                     - key_entry[1][1] * key_entry[2][0]);
        det = wrap26(det);
        det_inv = 0;
        for (r = 1; r < MODULUS; r++)
            if (det_inv == 0 && wrap26(det * r) == 1)
                det_inv = r;
        if (det_inv == 0)
            return 1'b0;
        if (n == 2) begin
            cipher_mat[0][0] = wrap26(key_entry[1][1] * det_inv);
            cipher_mat[0][1] = wrap26(-key_entry[0][1] * det_inv);
            cipher_mat[1][0] = wrap26(-key_entry[1][0] * det_inv);
            cipher_mat[1][1] = wrap26(key_entry[0][0] * det_inv);
        end else begin
            // adjugate: transposed signed minors
            for (r = 0; r < 3; r++) begin
                ra = (r == 0) ? 1 : 0;
                rb = (r == 2) ? 1 : 2;
                for (c = 0; c < 3; c++) begin
                    ca = (c == 0) ? 1 : 0;
                    cb = (c == 2) ? 1 : 2;
                    minor = key_entry[ra][ca] * key_entry[rb][cb]
                          - key_entry[ra][cb] * key_entry[rb][ca];
                    if ((r + c) % 2 == 1)
                        minor = -minor;
                    cipher_mat[c][r] = wrap26(minor * det_inv);
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic int cipher_block(input int n);
        int i, j, sum;
        for (i = 0; i < n; i++) begin
            sum = 0;
            for (j = 0; j < n; j++)
                sum += cipher_mat[i][j] * int'(held_letters[j]);
            block_out[i].letter = 5'(wrap26(sum));
            block_out[i].last = 1'b0;
            block_out[i].status = 1'b0;
        end
        return n;
    endfunction

    task automatic predict_cipher_byte(input logic [7:0] ch, input bit eot);
        int n, cnt, k;
        bit key_ok, is_letter;
        logic [4:0] letter;
        t_cipher_out err_out;
        n = (mirror_order == 2'd3) ? 3 : 2;
        cnt = 0;
        key_ok = load_cipher_matrix(mirror_key, mirror_decrypt, n);
        is_letter = 1'b0;
        letter = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            letter = 5'(ch - CHAR_UPPER_A);
            is_letter = 1'b1;
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            letter = 5'(ch - CHAR_LOWER_A);
            is_letter = 1'b1;
        end
        if (held_count >= n)
            held_count = 0;
        if (is_letter && key_ok) begin
            held_letters[held_count] = letter;
            held_count++;
            if (held_count == n) begin
                cnt = cipher_block(n);
                held_count = 0;
            end
        end
        if (eot && !key_ok) begin
            err_out.letter = '0;
            err_out.last = 1'b1;
            err_out.status = 1'b1;
            expected_out.push_back(err_out);
            held_count = 0;
        end else begin
            if (eot && held_count > 0) begin
                for (k = held_count; k < n; k++)
                    held_letters[k] = 5'(PAD_INDEX);
                cnt = cipher_block(n);
                held_count = 0;
            end
            if (eot && cnt > 0)
                block_out[cnt-1].last = 1'b1;
            for (k = 0; k < cnt; k++)
                expected_out.push_back(block_out[k]);
        end
    endtask

    task automatic note_mismatch(input string what, input t_cipher_out want,
                                 input t_cipher_out got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected letter %0d last %0d status %0d, got letter %0d last %0d status %0d",
                     what, want.letter, want.last, want.status,
                     got.letter, got.last, got.status);
    endtask

    always @(posedge i_clk) begin : result_check
        t_cipher_out got, want;
        if (i_rst_n && pop && !empty) begin
            got.letter = o_letter_index;
            got.last = o_last;
            got.status = o_status;
            if (expected_out.size() == 0) begin
                want = '0;
                note_mismatch("unexpected result", want, got);
            end else begin
                want = expected_out.pop_front();
                if (got !== want)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // receiver: runs of taking and stalling, each chosen at random
    always @(negedge i_clk) begin
        if (pop_left == 0) begin
            pop_level = ($urandom_range(0, 3) != 0);
            pop_left = pop_level ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end
        pop_left--;
        pop <= pop_level;
    end

    // one request: held until the block takes it, then predicted
    task automatic send_byte(input logic [7:0] ch, input bit eot);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        push <= 1'b1;
        i_char_byte <= ch;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (full);
        predict_cipher_byte(ch, eot);
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_BLOCK_SIZE) begin
            mirror_order = data[1:0];
            held_count = 0;
        end else if (idx == CFG_KEY_MATRIX) begin
            mirror_key = data;
        end else if (idx == CFG_DECRYPT_MODE) begin
            mirror_decrypt = data[0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_text(input string s, input bit eot);
        int k;
        for (k = 0; k < s.len(); k++)
            send_byte(s[k], eot && (k == s.len() - 1));
    endtask

    // identity key and order 2 straight out of reset; end mark with nothing held
    task automatic test_reset_values();
        send_text("hI!", 1'b1);
    endtask

    // padding of one and two letters, full block at end, end after a full block
    task automatic test_text_end();
        write_reg(CFG_KEY_MATRIX, KEY_PAIR);
        send_text("A", 1'b1);
        send_text("Bc", 1'b1);
        send_text("de#", 1'b1);
        write_reg(CFG_BLOCK_SIZE, KEY_W'(2'd3));
        write_reg(CFG_KEY_MATRIX, KEY_TRIPLE);
        send_text("xY5", 1'b1);
        send_text("q", 1'b1);
    endtask

    // bytes at the edges of the letter ranges and of the byte range
    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("@[`{Zz", 1'b1);
    endtask

    // inverse key, singular key in decrypt and in encrypt
    task automatic test_decrypt();
        write_reg(CFG_DECRYPT_MODE, KEY_W'(1'b1));
        send_text("KlmN", 1'b1);
        write_reg(CFG_KEY_MATRIX, '0);
        send_text("a", 1'b1);
        send_text(".", 1'b1);
        write_reg(CFG_DECRYPT_MODE, KEY_W'(1'b0));
        write_reg(CFG_BLOCK_SIZE, KEY_W'(2'd2));
        write_reg(CFG_KEY_MATRIX, {KEY_W{1'b1}});
        send_text("rs", 1'b1);
    endtask

    // odd block sizes, entries above 25, discard on size write, unused index
    task automatic test_register_corners();
        write_reg(CFG_BLOCK_SIZE, KEY_W'(2'd0));
        write_reg(CFG_KEY_MATRIX, KEY_WRAPPED);
        write_reg(CFG_DECRYPT_MODE, KEY_W'(1'b1));
        send_text("tu", 1'b0);
        write_reg(CFG_BLOCK_SIZE, KEY_W'(2'd1));
        send_text("v", 1'b0);
        write_reg(CFG_BLOCK_SIZE, KEY_W'(2'd3));
        send_text("wx", 1'b1);
        write_reg(CFG_UNUSED_IDX, KEY_W'({$urandom(), $urandom()}));
        write_reg(CFG_DECRYPT_MODE, KEY_W'(1'b0));
    endtask

    task automatic test_random_texts();
        int sent, texts, len, k, t, pick;
        logic [7:0] ch;
        logic [KEY_W-1:0] key;
        logic [1:0] order;
        bit dec, open_end, eot;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            order = 2'($urandom_range(0, 3));
            dec = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            key = KEY_W'({$urandom(), $urandom()});
            if (pick == 0)
                key = '0;
            else if (pick == 1)
                key = {KEY_W{1'b1}};
            else if (dec && pick > 3)
                // mostly invertible keys so that decrypt gets past the error path
                while (!load_cipher_matrix(key, 1'b1, (order == 2'd3) ? 3 : 2))
                    key = KEY_W'({$urandom(), $urandom()});
            write_reg(CFG_KEY_MATRIX, key);
            write_reg(CFG_DECRYPT_MODE, KEY_W'(dec));
            write_reg(CFG_BLOCK_SIZE, KEY_W'(order));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED_IDX, KEY_W'({$urandom(), $urandom()}));
            texts = $urandom_range(1, 3);
            for (t = 0; t < texts; t++) begin
                len = $urandom_range(1, 20);
                open_end = ($urandom_range(0, 5) == 0);
                for (k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        ch = CHAR_UPPER_A + 8'($urandom_range(0, 25));
                    else if (pick < 8)
                        ch = CHAR_LOWER_A + 8'($urandom_range(0, 25));
                    else
                        ch = 8'($urandom_range(0, 255));
                    eot = !open_end && (k == len - 1);
                    send_byte(ch, eot);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_text_end();
        test_byte_extremes();
        test_decrypt();
        test_register_corners();
        test_random_texts();
        settle_idle();
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
